// ----- src/sorted_insert_table_macros.svh -----
// Assertion macros for the sorted insert table checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SORTED_INSERT_TABLE_MACROS_SVH
`define SORTED_INSERT_TABLE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SIT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sit_pkg.sv -----
// Shared types and constants for the sorted insert table.
// No dependencies.
package sit_pkg;

  localparam int unsigned DefaultCapacity = 1024;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned ReadIdxW        = 10;
  localparam int unsigned CountOutW       = 11;
  localparam int unsigned FuncW           = 2;
  localparam int unsigned InDataW         = 48;
  localparam int unsigned OutDataW        = 48;

  typedef logic signed [ValueW-1:0] sit_value_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } sit_func_e;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic       insert;
    logic       launch;
    sit_value_t value;
  } sit_cell_ctrl_t;

  typedef struct packed {
    logic                 rejected;
    logic [CountOutW-1:0] entry_count;
    sit_value_t           read_value;
  } sit_result_t;

endpackage

// ----- src/sit_cell.sv -----
// One table entry of the sorted insert chain.
// Depends on sit_pkg.
module sit_cell #(
  parameter int unsigned CAPACITY = sit_pkg::DefaultCapacity,
  parameter int unsigned INDEX    = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sit_pkg::sit_cell_ctrl_t            ctrl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]      count_i,
  input  logic [$clog2(CAPACITY)-1:0]        idx_i,
  input  sit_pkg::sit_value_t                prev_value_i,
  input  logic                               prev_keep_i,
  input  logic                               up_cv_i,
  input  sit_pkg::sit_value_t                up_cd_i,
  output sit_pkg::sit_value_t                value_o,
  output logic                               keep_o,
  output logic                               cv_o,
  output sit_pkg::sit_value_t                cd_o
);
  import sit_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  sit_value_t value_q, value_d;
  logic       cv_q, cv_d;
  sit_value_t cd_q, cd_d;
  logic       valid;

  assign valid  = CW'(INDEX) < count_i;
  // Entry stays put when it is smaller than the new value.
  assign keep_o = valid && (value_q < ctrl_i.value);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert && !keep_o) begin
      value_d = prev_keep_i ? ctrl_i.value : prev_value_i;
    end
  end

  // Read carry walks one cell toward cell 0 per cycle.
  always_comb begin
    if (ctrl_i.launch) begin
      cv_d = (idx_i == AW'(INDEX));
      cd_d = value_q;
    end else begin
      cv_d = up_cv_i;
      cd_d = up_cd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cd_q    <= cd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else begin
      cv_q <= cv_d;
    end
  end

  assign value_o = value_q;
  assign cv_o    = cv_q;
  assign cd_o    = cd_q;

endmodule

// ----- src/sit_out_fifo.sv -----
// Two-entry result queue in front of the master stream port.
// Depends on sit_pkg.
module sit_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sit_pkg::sit_result_t push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output logic                 full_o,
  output sit_pkg::sit_result_t data_o
);
  import sit_pkg::*;

  sit_result_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- src/sorted_insert_table.sv -----
// Sorted insert table: CAPACITY signed 32-bit entries kept in ascending order
// in a chain of compare-and-shift cells, one entry per cell.
// Channels: slave stream takes a request (tuser = func, tdata = new_value,
// read_index); master stream returns one result per request (tdata =
// read_value, entry_count; tuser = rejected).
// Insert: every cell compares in parallel and the larger entries move up one
// cell in the accept cycle; the new value lands before equal entries.
// Path from accept to result: an insert, clear, dropped insert, out-of-range
// read or unused code registers its result, which then enters the output
// queue; a read at index i launches a read carry that walks one cell per cycle
// to cell 0, where it enters the queue. One request is in flight at a time;
// the next one can be taken in the cycle after its result is pushed into the
// output queue, if the queue is not full.
// A two-entry output queue lets a request be accepted while a result still
// waits; with the queue full, s_axis_tready drops until the receiver takes one.
// Reset clears the count and the control state; entry contents are not reset
// and are never visible before they are written.
// Depends on sit_pkg, sit_cell, sit_out_fifo.
module sorted_insert_table #(
  parameter int unsigned CAPACITY = sit_pkg::DefaultCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] new_value, [41:32] read_index, [47:42] zero
  input  logic [sit_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] func
  input  logic [sit_pkg::FuncW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] read_value, [42:32] entry_count, [47:43] zero
  output logic [sit_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] rejected
  output logic                          m_axis_tuser
);
  import sit_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  // Compare width for read_index against the count.
  localparam int unsigned MW = (CW > ReadIdxW) ? CW : ReadIdxW;

  // Request fields
  sit_func_e              func;
  sit_value_t             new_value;
  logic [ReadIdxW-1:0]    read_index;
  logic                   acc;

  // Control
  logic [CW-1:0]          count_q, count_d;
  logic                   busy_q, busy_d;
  logic                   pend_valid_q, pend_valid_d;
  sit_result_t            pend_res_q, pend_res_d;
  logic                   full_tbl;
  logic                   in_range;
  sit_cell_ctrl_t         cell_ctrl;

  // Chain wiring
  sit_value_t             cell_val  [CAPACITY];
  logic                   cell_keep [CAPACITY];
  logic                   cell_cv   [CAPACITY];
  sit_value_t             cell_cd   [CAPACITY];

  // Output queue
  logic                   push;
  sit_result_t            push_res;
  logic                   fifo_full;
  sit_result_t            out_res;

  assign func       = sit_func_e'(s_axis_tuser);
  assign new_value  = s_axis_tdata[ValueW-1:0];
  assign read_index = s_axis_tdata[ValueW+ReadIdxW-1:ValueW];

  assign s_axis_tready = !busy_q && !fifo_full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign full_tbl = (count_q == CW'(CAPACITY));
  // Count never exceeds CAPACITY, so this also keeps the index in the table.
  assign in_range = MW'(read_index) < MW'(count_q);

  // Request decode
  always_comb begin
    cell_ctrl.insert = 1'b0;
    cell_ctrl.launch = 1'b0;
    cell_ctrl.value  = new_value;
    count_d          = count_q;
    pend_valid_d     = 1'b0;
    pend_res_d.read_value  = '0;
    pend_res_d.entry_count = CountOutW'(count_q);
    pend_res_d.rejected    = 1'b0;
    if (acc) begin
      unique case (func)
        FUNC_INSERT: begin
          pend_valid_d = 1'b1;
          if (full_tbl) begin
            pend_res_d.rejected = 1'b1;
          end else begin
            cell_ctrl.insert       = 1'b1;
            count_d                = count_q + CW'(1);
            pend_res_d.entry_count = CountOutW'(count_d);
          end
        end
        FUNC_READ: begin
          if (in_range) begin
            cell_ctrl.launch = 1'b1;
          end else begin
            pend_valid_d        = 1'b1;
            pend_res_d.rejected = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          pend_valid_d           = 1'b1;
          count_d                = '0;
          pend_res_d.entry_count = '0;
        end
        default: begin
          pend_valid_d = 1'b1;
        end
      endcase
    end
  end

  // Result into the queue: either a decoded result or a read carry at cell 0.
  always_comb begin
    push = pend_valid_q || cell_cv[0];
    if (cell_cv[0]) begin
      push_res.read_value  = cell_cd[0];
      push_res.entry_count = CountOutW'(count_q);
      push_res.rejected    = 1'b0;
    end else begin
      push_res = pend_res_q;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (acc) begin
      busy_d = 1'b1;
    end else if (push) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Cell chain: values hand up on insert, read carry hands down.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sit_value_t prev_value;
    logic       prev_keep;
    logic       up_cv;
    sit_value_t up_cd;

    if (g == 0) begin : g_first
      assign prev_value = '0;
      assign prev_keep  = 1'b1;
    end else begin : g_mid
      assign prev_value = cell_val[g-1];
      assign prev_keep  = cell_keep[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign up_cv = 1'b0;
      assign up_cd = '0;
    end else begin : g_up
      assign up_cv = cell_cv[g+1];
      assign up_cd = cell_cd[g+1];
    end

    sit_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .count_i      (count_q),
      .idx_i        (AW'(read_index)),
      .prev_value_i (prev_value),
      .prev_keep_i  (prev_keep),
      .up_cv_i      (up_cv),
      .up_cd_i      (up_cd),
      .value_o      (cell_val[g]),
      .keep_o       (cell_keep[g]),
      .cv_o         (cell_cv[g]),
      .cd_o         (cell_cd[g])
    );
  end

  sit_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .full_o      (fifo_full),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {(OutDataW - ValueW - CountOutW)'(0),
                         out_res.entry_count, out_res.read_value};
  assign m_axis_tuser = out_res.rejected;

endmodule

// ----- src/sit_checker.sv -----
// Port-level checker for the sorted insert table, bound to the top level.
// Depends on sit_pkg and sorted_insert_table_macros.svh.
`include "sorted_insert_table_macros.svh"

module sit_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sit_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [sit_pkg::FuncW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sit_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);
  import sit_pkg::*;

  logic in_acc;
  logic out_stall;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // One request in flight: ready drops right after an accept.
  `SIT_ASSERT_NEXT(a_one_in_flight, in_acc, !s_axis_tready, "request accepted while busy")

  // With no result waiting at an accept, none shows in the cycle right after it.
  `SIT_ASSERT_NEXT(a_min_latency, in_acc && !m_axis_tvalid, !m_axis_tvalid,
                   "result earlier than two cycles")

  // A rejected request carries a zero read value.
  `SIT_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata[ValueW-1:0] == '0, "rejected result with data")

  // Stalled result holds.
  `SIT_ASSERT_NEXT(a_out_hold, out_stall,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "stalled result changed")

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
